// ===== sv/ipacl_pkg.sv =====
// shared types, constants and codes for the ip address acl filter
package ipacl_pkg;

    // table sizes
    localparam int SINGLE_RULES = 16;
    localparam int RANGE_RULES  = 16;

    // entry index widths (at least one bit)
    localparam int SIDX_W = (SINGLE_RULES > 1) ? $clog2(SINGLE_RULES) : 1;
    localparam int RIDX_W = (RANGE_RULES > 1) ? $clog2(RANGE_RULES) : 1;

    localparam int ADDR_W = 32;
    localparam logic [ADDR_W-1:0] ADDR_ALL_ONES = 32'hffffffff;
    localparam logic [5:0] PREFIX_FULL = 6'd32;

    // command codes
    typedef enum logic [2:0] {
        CMD_ADD_SINGLE = 3'd0,
        CMD_ADD_CIDR   = 3'd1,
        CMD_ADD_RANGE  = 3'd2,
        CMD_CLEAR      = 3'd3,
        CMD_CHECK      = 3'd4
    } acl_cmd_t;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_DUP_KEY  = 2'd1,
        ST_REVERSED = 2'd2,
        ST_FULL     = 2'd3
    } acl_status_t;

    // controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_LAUNCH,
        S_SCAN,
        S_COMMIT
    } acl_state_t;

    // token walking the single-address chain
    typedef struct packed {
        logic              active;
        logic              check;
        logic [ADDR_W-1:0] addr;
        logic              dup;
        logic              free_found;
        logic [SIDX_W-1:0] free_idx;
        logic              seen_allow;
        logic              seen_deny;
    } acl_stok_t;

    // token walking the range chain
    typedef struct packed {
        logic              active;
        logic              check;
        logic [ADDR_W-1:0] addr;
        logic              dup;
        logic              free_found;
        logic [RIDX_W-1:0] free_idx;
        logic              seen_allow;
        logic              seen_deny;
    } acl_rtok_t;

    // write into one single-address entry
    typedef struct packed {
        logic              en;
        logic [SIDX_W-1:0] idx;
        logic [ADDR_W-1:0] addr;
        logic              allow;
    } acl_swr_t;

    // write into one range entry
    typedef struct packed {
        logic              en;
        logic [RIDX_W-1:0] idx;
        logic [ADDR_W-1:0] lo;
        logic [ADDR_W-1:0] hi;
        logic              allow;
    } acl_rwr_t;

endpackage

// ===== sv/ipacl_single_cell.sv =====
// one exact-address rule entry with its stage of the lookup chain
module ipacl_single_cell (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic [ipacl_pkg::SIDX_W-1:0]   cell_index,
    input  logic                           clear,
    input  ipacl_pkg::acl_swr_t            wr,
    input  ipacl_pkg::acl_stok_t           tok_in,
    output ipacl_pkg::acl_stok_t           tok_out
);

    logic                          valid_reg;
    logic [ipacl_pkg::ADDR_W-1:0]  addr_reg;
    logic                          allow_reg;
    ipacl_pkg::acl_stok_t          tok_reg;
    ipacl_pkg::acl_stok_t          tok_next;
    logic                          match;
    logic                          wr_hit;

    assign wr_hit = wr.en && (wr.idx == cell_index);
    assign match  = valid_reg && (addr_reg == tok_in.addr);

    // fold this entry into the passing token
    always_comb begin
        tok_next = tok_in;
        if (match) begin
            if (tok_in.check) begin
                if (allow_reg) begin
                    tok_next.seen_allow = 1'b1;
                end else begin
                    tok_next.seen_deny = 1'b1;
                end
            end else begin
                tok_next.dup = 1'b1;
            end
        end
        if (!valid_reg && !tok_in.free_found) begin
            tok_next.free_found = 1'b1;
            tok_next.free_idx   = cell_index;
        end
    end

    // token stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg.active <= 1'b0;
        end else begin
            tok_reg <= tok_next;
        end
    end

    // entry valid bit
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (clear) begin
            valid_reg <= 1'b0;
        end else if (wr_hit) begin
            valid_reg <= 1'b1;
        end
    end

    // entry payload
    always_ff @(posedge aclk) begin
        if (wr_hit) begin
            addr_reg  <= wr.addr;
            allow_reg <= wr.allow;
        end
    end

    assign tok_out = tok_reg;

endmodule

// ===== sv/ipacl_range_cell.sv =====
// one address-range rule entry with its stage of the lookup chain
module ipacl_range_cell (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic [ipacl_pkg::RIDX_W-1:0]   cell_index,
    input  logic                           clear,
    input  ipacl_pkg::acl_rwr_t            wr,
    input  ipacl_pkg::acl_rtok_t           tok_in,
    output ipacl_pkg::acl_rtok_t           tok_out
);

    logic                          valid_reg;
    logic [ipacl_pkg::ADDR_W-1:0]  lo_reg;
    logic [ipacl_pkg::ADDR_W-1:0]  hi_reg;
    logic                          allow_reg;
    ipacl_pkg::acl_rtok_t          tok_reg;
    ipacl_pkg::acl_rtok_t          tok_next;
    logic                          in_range;
    logic                          key_hit;
    logic                          wr_hit;

    assign wr_hit   = wr.en && (wr.idx == cell_index);
    assign in_range = valid_reg && (lo_reg <= tok_in.addr) && (tok_in.addr <= hi_reg);
    assign key_hit  = valid_reg && (lo_reg == tok_in.addr);

    // fold this entry into the passing token
    always_comb begin
        tok_next = tok_in;
        if (tok_in.check) begin
            if (in_range) begin
                if (allow_reg) begin
                    tok_next.seen_allow = 1'b1;
                end else begin
                    tok_next.seen_deny = 1'b1;
                end
            end
        end else if (key_hit) begin
            tok_next.dup = 1'b1;
        end
        if (!valid_reg && !tok_in.free_found) begin
            tok_next.free_found = 1'b1;
            tok_next.free_idx   = cell_index;
        end
    end

    // token stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg.active <= 1'b0;
        end else begin
            tok_reg <= tok_next;
        end
    end

    // entry valid bit
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (clear) begin
            valid_reg <= 1'b0;
        end else if (wr_hit) begin
            valid_reg <= 1'b1;
        end
    end

    // entry payload
    always_ff @(posedge aclk) begin
        if (wr_hit) begin
            lo_reg    <= wr.lo;
            hi_reg    <= wr.hi;
            allow_reg <= wr.allow;
        end
    end

    assign tok_out = tok_reg;

endmodule

// ===== sv/ip_address_acl_filter_core.sv =====
// ipv4 access-control engine: controller plus exact-address and range rule chains
//
// Input channel s_*: one beat carries a command (add single address, add cidr
// prefix, add range, clear all, check address) with its operands. Output
// channel m_*: exactly one beat per command, a status (ok, duplicate key,
// reversed range, table full) and an accept verdict for checks.
// The filter mode (blacklist or whitelist) is written through cfg_wr_en and
// cfg_wr_data; the user must write it only while idle (the block has no guard).
// Each command sends a token down two rows of rule cells, one entry per cell,
// one cell per cycle; the token gathers duplicate, free-slot and match flags.
// One command is in flight at a time: a new input beat is taken only in idle.
// Adds are written into the lowest free entry when the token has passed.
// The output beat sits in a register: while it waits on m_ready the next
// command is still taken and scanned, and only its write-back and result
// wait for the register to empty.
// Reset (aresetn, synchronous, active low) empties both tables, drops any
// pending result and sets blacklist mode.
module ip_address_acl_filter_core (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,
    // command beats
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_command,
    input  logic [31:0] s_address,
    input  logic [31:0] s_address_end,
    input  logic [5:0]  s_prefix_length,
    input  logic        s_allow_rule,
    // result beats
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic        m_accept
);

    localparam int SN = ipacl_pkg::SINGLE_RULES;
    localparam int RN = ipacl_pkg::RANGE_RULES;

    ipacl_pkg::acl_state_t         state_reg;
    ipacl_pkg::acl_state_t         state_next;

    logic                          filter_mode_reg;
    logic [2:0]                    cmd_reg;
    logic [ipacl_pkg::ADDR_W-1:0]  addr_reg;
    logic [ipacl_pkg::ADDR_W-1:0]  hi_reg;
    logic                          allow_reg;

    logic [ipacl_pkg::ADDR_W-1:0]  pfx_mask;
    logic [ipacl_pkg::ADDR_W-1:0]  lo_in;
    logic [ipacl_pkg::ADDR_W-1:0]  hi_in;

    ipacl_pkg::acl_stok_t          s_chain [SN+1];
    ipacl_pkg::acl_rtok_t          r_chain [RN+1];
    ipacl_pkg::acl_stok_t          s_res_reg;
    ipacl_pkg::acl_rtok_t          r_res_reg;
    logic                          s_done_reg;
    logic                          r_done_reg;

    logic                          launch;
    logic                          commit_fire;
    logic                          out_free;
    logic                          in_fire;
    logic                          tbl_clear;
    ipacl_pkg::acl_swr_t           swr;
    ipacl_pkg::acl_rwr_t           rwr;
    logic [1:0]                    status_c;
    logic                          accept_c;
    logic                          seen_allow;
    logic                          seen_deny;

    logic                          m_valid_reg;
    logic                          m_valid_next;
    logic [1:0]                    m_status_reg;
    logic                          m_accept_reg;

    assign in_fire  = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    // filter mode register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            filter_mode_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            filter_mode_reg <= cfg_wr_data;
        end
    end

    // cidr expansion to network and broadcast addresses
    always_comb begin
        if (s_prefix_length >= ipacl_pkg::PREFIX_FULL) begin
            pfx_mask = ipacl_pkg::ADDR_ALL_ONES;
        end else begin
            pfx_mask = ~(ipacl_pkg::ADDR_ALL_ONES >> s_prefix_length);
        end
        if (s_command == ipacl_pkg::CMD_ADD_CIDR) begin
            lo_in = s_address & pfx_mask;
            hi_in = (s_address & pfx_mask) | ~pfx_mask;
        end else begin
            lo_in = s_address;
            hi_in = s_address_end;
        end
    end

    // command capture
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            cmd_reg   <= s_command;
            addr_reg  <= lo_in;
            hi_reg    <= hi_in;
            allow_reg <= s_allow_rule;
        end
    end

    // token launch into both chains
    always_comb begin
        s_chain[0]            = '0;
        s_chain[0].active     = launch;
        s_chain[0].check      = (cmd_reg == ipacl_pkg::CMD_CHECK);
        s_chain[0].addr       = addr_reg;
        r_chain[0]            = '0;
        r_chain[0].active     = launch;
        r_chain[0].check      = (cmd_reg == ipacl_pkg::CMD_CHECK);
        r_chain[0].addr       = addr_reg;
    end

    // exact-address rule cells
    for (genvar i = 0; i < SN; i++) begin : g_single
        ipacl_single_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .cell_index (ipacl_pkg::SIDX_W'(i)),
            .clear      (tbl_clear),
            .wr         (swr),
            .tok_in     (s_chain[i]),
            .tok_out    (s_chain[i+1])
        );
    end

    // range rule cells
    for (genvar j = 0; j < RN; j++) begin : g_range
        ipacl_range_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .cell_index (ipacl_pkg::RIDX_W'(j)),
            .clear      (tbl_clear),
            .wr         (rwr),
            .tok_in     (r_chain[j]),
            .tok_out    (r_chain[j+1])
        );
    end

    // catch tokens leaving the chains
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s_done_reg <= 1'b0;
            r_done_reg <= 1'b0;
        end else if (launch) begin
            s_done_reg <= 1'b0;
            r_done_reg <= 1'b0;
        end else begin
            if (s_chain[SN].active) begin
                s_done_reg <= 1'b1;
            end
            if (r_chain[RN].active) begin
                r_done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_chain[SN].active) begin
            s_res_reg <= s_chain[SN];
        end
        if (r_chain[RN].active) begin
            r_res_reg <= r_chain[RN];
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ipacl_pkg::S_IDLE: begin
                if (in_fire) begin
                    state_next = ipacl_pkg::S_LAUNCH;
                end
            end
            ipacl_pkg::S_LAUNCH: begin
                state_next = ipacl_pkg::S_SCAN;
            end
            ipacl_pkg::S_SCAN: begin
                if (s_done_reg && r_done_reg) begin
                    state_next = ipacl_pkg::S_COMMIT;
                end
            end
            ipacl_pkg::S_COMMIT: begin
                if (out_free) begin
                    state_next = ipacl_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = ipacl_pkg::S_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb begin
        s_ready     = 1'b0;
        launch      = 1'b0;
        commit_fire = 1'b0;
        unique case (state_reg)
            ipacl_pkg::S_IDLE:   s_ready     = 1'b1;
            ipacl_pkg::S_LAUNCH: launch      = 1'b1;
            ipacl_pkg::S_SCAN:   launch      = 1'b0;
            ipacl_pkg::S_COMMIT: commit_fire = out_free;
            default:             s_ready     = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ipacl_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // verdict from gathered match flags
    assign seen_allow = s_res_reg.seen_allow || r_res_reg.seen_allow;
    assign seen_deny  = s_res_reg.seen_deny || r_res_reg.seen_deny;

    // decide status, table write-back and verdict
    always_comb begin
        status_c  = ipacl_pkg::ST_OK;
        accept_c  = 1'b0;
        tbl_clear = 1'b0;
        swr       = '0;
        rwr       = '0;
        swr.idx   = s_res_reg.free_idx;
        swr.addr  = addr_reg;
        swr.allow = allow_reg;
        rwr.idx   = r_res_reg.free_idx;
        rwr.lo    = addr_reg;
        rwr.hi    = hi_reg;
        rwr.allow = allow_reg;
        unique case (cmd_reg)
            ipacl_pkg::CMD_ADD_SINGLE: begin
                if (s_res_reg.dup) begin
                    status_c = ipacl_pkg::ST_DUP_KEY;
                end else if (!s_res_reg.free_found) begin
                    status_c = ipacl_pkg::ST_FULL;
                end else begin
                    swr.en = commit_fire;
                end
            end
            ipacl_pkg::CMD_ADD_CIDR, ipacl_pkg::CMD_ADD_RANGE: begin
                if (addr_reg > hi_reg) begin
                    status_c = ipacl_pkg::ST_REVERSED;
                end else if (r_res_reg.dup) begin
                    status_c = ipacl_pkg::ST_DUP_KEY;
                end else if (!r_res_reg.free_found) begin
                    status_c = ipacl_pkg::ST_FULL;
                end else begin
                    rwr.en = commit_fire;
                end
            end
            ipacl_pkg::CMD_CLEAR: begin
                tbl_clear = commit_fire;
            end
            ipacl_pkg::CMD_CHECK: begin
                if (seen_allow) begin
                    accept_c = !seen_deny;
                end else if (seen_deny) begin
                    accept_c = 1'b0;
                end else begin
                    accept_c = !filter_mode_reg;
                end
            end
            default: begin
                status_c = ipacl_pkg::ST_OK;
            end
        endcase
    end

    // output register
    always_comb begin
        if (commit_fire) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (commit_fire) begin
            m_status_reg <= status_c;
            m_accept_reg <= accept_c;
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_status = m_status_reg;
    assign m_accept = m_accept_reg;

endmodule

// ===== bench/tb_ip_address_acl_filter_core.sv =====
// testbench for the ipv4 acl filter core: scoreboard class, stimulus and checks
import ipacl_pkg::*;

// predicts each result from its own copy of both rule tables and the filter mode
class acl_scoreboard;
    typedef struct {
        acl_status_t status;
        logic        accept;
    } verdict_t;

    logic              mode;
    logic              sgl_used  [SINGLE_RULES];
    logic [ADDR_W-1:0] sgl_addr  [SINGLE_RULES];
    logic              sgl_allow [SINGLE_RULES];
    logic              rng_used  [RANGE_RULES];
    logic [ADDR_W-1:0] rng_lo    [RANGE_RULES];
    logic [ADDR_W-1:0] rng_hi    [RANGE_RULES];
    logic              rng_allow [RANGE_RULES];
    verdict_t          awaited[$];

    int errors;
    int n_results;
    int n_checks;
    int n_accepts;
    int n_added;
    int n_dup;
    int n_rev;
    int n_full;
    int n_clears;
    int mode_seen[2];

    function new();
        mode = 1'b0;
        wipe_tables();
        errors    = 0;
        n_results = 0;
        n_checks  = 0;
        n_accepts = 0;
        n_added   = 0;
        n_dup     = 0;
        n_rev     = 0;
        n_full    = 0;
        n_clears  = 0;
        mode_seen[0] = 0;
        mode_seen[1] = 0;
    endfunction

    function void wipe_tables();
        foreach (sgl_used[i]) sgl_used[i] = 1'b0;
        foreach (rng_used[i]) rng_used[i] = 1'b0;
    endfunction

    function void set_mode(logic m);
        mode = m;
    endfunction

    function int pending();
        return awaited.size();
    endfunction

    // lowest free entry, unless the address is already a key
    function acl_status_t insert_single(logic [ADDR_W-1:0] a, logic allow);
        int slot;
        slot = -1;
        for (int i = 0; i < SINGLE_RULES; i++) begin
            if (sgl_used[i]) begin
                if (sgl_addr[i] == a) return ST_DUP_KEY;
            end else if (slot < 0) begin
                slot = i;
            end
        end
        if (slot < 0) return ST_FULL;
        sgl_used[slot]  = 1'b1;
        sgl_addr[slot]  = a;
        sgl_allow[slot] = allow;
        return ST_OK;
    endfunction

    // reversed range wins over duplicate begin, which wins over full table
    function acl_status_t insert_range(logic [ADDR_W-1:0] lo, logic [ADDR_W-1:0] hi,
                                       logic allow);
        int slot;
        slot = -1;
        if (lo > hi) return ST_REVERSED;
        for (int i = 0; i < RANGE_RULES; i++) begin
            if (rng_used[i]) begin
                if (rng_lo[i] == lo) return ST_DUP_KEY;
            end else if (slot < 0) begin
                slot = i;
            end
        end
        if (slot < 0) return ST_FULL;
        rng_used[slot]  = 1'b1;
        rng_lo[slot]    = lo;
        rng_hi[slot]    = hi;
        rng_allow[slot] = allow;
        return ST_OK;
    endfunction

    // network mask; prefixes beyond 32 act as 32
    function logic [ADDR_W-1:0] cidr_mask(logic [5:0] plen);
        if (plen >= PREFIX_FULL) return ADDR_ALL_ONES;
        if (plen == 6'd0) return '0;
        return ADDR_ALL_ONES << (32 - plen);
    endfunction

    // mixed allow and deny matches deny, no match follows the mode
    function logic address_verdict(logic [ADDR_W-1:0] a);
        logic any_allow;
        logic any_deny;
        any_allow = 1'b0;
        any_deny  = 1'b0;
        for (int i = 0; i < SINGLE_RULES; i++) begin
            if (sgl_used[i] && sgl_addr[i] == a) begin
                if (sgl_allow[i]) any_allow = 1'b1;
                else any_deny = 1'b1;
            end
        end
        for (int i = 0; i < RANGE_RULES; i++) begin
            if (rng_used[i] && rng_lo[i] <= a && a <= rng_hi[i]) begin
                if (rng_allow[i]) any_allow = 1'b1;
                else any_deny = 1'b1;
            end
        end
        if (any_allow && any_deny) return 1'b0;
        if (any_allow) return 1'b1;
        if (any_deny) return 1'b0;
        return !mode;
    endfunction

    // accepted input beat: update tables and queue the expected result
    function void note_command(logic [2:0] cmd, logic [ADDR_W-1:0] a,
                               logic [ADDR_W-1:0] a_end, logic [5:0] plen, logic allow);
        verdict_t          v;
        logic [ADDR_W-1:0] m;
        v.status = ST_OK;
        v.accept = 1'b0;
        case (cmd)
            CMD_ADD_SINGLE: begin
                v.status = insert_single(a, allow);
            end
            CMD_ADD_CIDR: begin
                m = cidr_mask(plen);
                v.status = insert_range(a & m, a | ~m, allow);
            end
            CMD_ADD_RANGE: begin
                v.status = insert_range(a, a_end, allow);
            end
            CMD_CLEAR: begin
                wipe_tables();
                n_clears++;
            end
            CMD_CHECK: begin
                v.accept = address_verdict(a);
                n_checks++;
                n_accepts += int'(v.accept);
                mode_seen[mode]++;
            end
            default: begin
            end
        endcase
        if (cmd == CMD_ADD_SINGLE || cmd == CMD_ADD_CIDR || cmd == CMD_ADD_RANGE) begin
            case (v.status)
                ST_OK:       n_added++;
                ST_DUP_KEY:  n_dup++;
                ST_REVERSED: n_rev++;
                ST_FULL:     n_full++;
                default: begin
                end
            endcase
        end
        awaited = {awaited, v};
    endfunction

    // accepted output beat against the oldest expectation
    function void check_result(logic [1:0] status, logic accept);
        verdict_t v;
        n_results++;
        if (awaited.size() == 0) begin
            $display("%0t: result beat with nothing outstanding, status %0d accept %0d",
                     $time, status, accept);
            errors++;
            return;
        end
        v = awaited.pop_front();
        if (status !== v.status) begin
            $display("%0t: status mismatch, expected %0d actual %0d",
                     $time, v.status, status);
            errors++;
        end
        if (accept !== v.accept) begin
            $display("%0t: accept mismatch, expected %0d actual %0d",
                     $time, v.accept, accept);
            errors++;
        end
    endfunction

    function void flush_leftovers();
        if (awaited.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, awaited.size());
            errors += awaited.size();
        end
    endfunction
endclass

module tb_ip_address_acl_filter_core;

    localparam logic [2:0] CMD_RSVD_FIRST = 3'd5;
    localparam logic [2:0] CMD_RSVD_LAST  = 3'd7;
    localparam int PHASES        = 8;
    localparam int PHASE_ITEMS   = 100;
    localparam int SETTLE_CYCLES = 30;
    localparam int HOLD_CYCLES   = 400;

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic        cfg_wr_data;
    logic        s_valid;
    logic        s_ready;
    logic [2:0]  s_command;
    logic [31:0] s_address;
    logic [31:0] s_address_end;
    logic [5:0]  s_prefix_length;
    logic        s_allow_rule;
    logic        m_valid;
    logic        m_ready;
    logic [1:0]  m_status;
    logic        m_accept;

    acl_scoreboard sb = new();

    logic [31:0] recent_keys[$];
    int          burst_left;
    int          items_sent;
    logic        hold_off_req;

    ip_address_acl_filter_core u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_command       (s_command),
        .s_address       (s_address),
        .s_address_end   (s_address_end),
        .s_prefix_length (s_prefix_length),
        .s_allow_rule    (s_allow_rule),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_accept        (m_accept)
    );

    // clock
    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // watchdog
    initial begin
        #4000000;
        $display("tb_ip_address_acl_filter_core NOT OK");
        $finish;
    end

    // result beats
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_result(m_status, m_accept);
        end
    end

    // receiver: random ready with a varying duty, plus one long hold-off on request
    initial begin : rx_side
        int pct;
        int cyc;
        int hold;
        m_ready = 1'b0;
        pct  = 100;
        cyc  = 0;
        hold = 0;
        forever begin
            @(negedge aclk);
            if (hold_off_req && hold == 0) begin
                hold = HOLD_CYCLES;
                hold_off_req = 1'b0;
            end
            if (cyc % 50 == 0) begin
                case ($urandom_range(0, 4))
                    0, 1: pct = 100;
                    2: pct = 75;
                    3: pct = 40;
                    default: pct = 10;
                endcase
            end
            cyc++;
            if (hold != 0) begin
                hold--;
                m_ready = 1'b0;
            end else begin
                m_ready = ($urandom_range(0, 99) < pct);
            end
        end
    end

    // one command beat; returns once accepted
    task automatic issue(input logic [2:0] cmd, input logic [31:0] a, input logic [31:0] a_end,
                         input logic [5:0] plen, input logic allow);
        @(negedge aclk);
        s_valid         = 1'b1;
        s_command       = cmd;
        s_address       = a;
        s_address_end   = a_end;
        s_prefix_length = plen;
        s_allow_rule    = allow;
        do @(posedge aclk); while (!s_ready);
        sb.note_command(cmd, a, a_end, plen, allow);
        if (cmd < CMD_RSVD_FIRST) items_sent++;
    endtask

    // sender bursts with random gaps between them
    task automatic pace_sender();
        int gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                @(negedge aclk);
                s_valid = 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
        end
        burst_left--;
    endtask

    // drop valid and wait for every expected result, then let the block go quiet
    task automatic settle();
        int n;
        @(negedge aclk);
        s_valid = 1'b0;
        for (n = 0; n < 20000 && sb.pending() != 0; n++) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_filter_mode(input logic m);
        @(negedge aclk);
        cfg_wr_en   = 1'b1;
        cfg_wr_data = m;
        sb.set_mode(m);
        @(negedge aclk);
        cfg_wr_en   = 1'b0;
    endtask

    // addresses clustered so rules collide and checks hit them
    function automatic logic [31:0] pick_address();
        case ($urandom_range(0, 5))
            0, 1: return 32'h0a000000 + $urandom_range(0, 47);
            2: return 32'hc0a80000 | ($urandom_range(0, 3) << 8) | $urandom_range(0, 255);
            3: return $urandom_range(0, 1) ? ADDR_ALL_ONES - $urandom_range(0, 3)
                                           : $urandom_range(0, 3);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] rule_key();
        if (recent_keys.size() != 0 && $urandom_range(0, 3) == 0)
            return recent_keys[$urandom_range(0, recent_keys.size() - 1)];
        return pick_address();
    endfunction

    task automatic random_add();
        logic [31:0] key;
        logic [31:0] hi;
        logic [5:0]  plen;
        key = rule_key();
        recent_keys = {recent_keys, key};
        if (recent_keys.size() > 32) void'(recent_keys.pop_front());
        case ($urandom_range(0, 2))
            0: begin
                issue(CMD_ADD_SINGLE, key, $urandom, 6'($urandom),
                      1'($urandom_range(0, 1)));
            end
            1: begin
                plen = ($urandom_range(0, 6) == 0) ? 6'($urandom_range(0, 63))
                                                   : 6'($urandom_range(20, 32));
                issue(CMD_ADD_CIDR, key ^ $urandom_range(0, 255), $urandom, plen,
                      1'($urandom_range(0, 1)));
            end
            default: begin
                hi = ($urandom_range(0, 9) == 0) ? $urandom : key + $urandom_range(0, 40);
                issue(CMD_ADD_RANGE, key, hi, 6'($urandom), 1'($urandom_range(0, 1)));
            end
        endcase
    endtask

    task automatic random_check();
        logic [31:0] a;
        if (recent_keys.size() != 0 && $urandom_range(0, 4) < 3)
            a = recent_keys[$urandom_range(0, recent_keys.size() - 1)]
                + $urandom_range(0, 20) - 2;
        else
            a = pick_address();
        issue(CMD_CHECK, a, $urandom, 6'($urandom), 1'($urandom_range(0, 1)));
    endtask

    task automatic random_command();
        int r;
        r = $urandom_range(0, 99);
        if (r < 2)
            issue(3'($urandom_range(CMD_RSVD_FIRST, CMD_RSVD_LAST)), $urandom, $urandom,
                  6'($urandom), 1'($urandom_range(0, 1)));
        else if (r < 5)
            issue(CMD_CLEAR, $urandom, $urandom, 6'($urandom), 1'($urandom_range(0, 1)));
        else if (r < 52)
            random_check();
        else
            random_add();
    endtask

    // main sequence
    initial begin : stimulus
        int fill;
        int phase_start;
        aresetn         = 1'b0;
        cfg_wr_en       = 1'b0;
        cfg_wr_data     = 1'b0;
        s_valid         = 1'b0;
        s_command       = CMD_CHECK;
        s_address       = '0;
        s_address_end   = '0;
        s_prefix_length = '0;
        s_allow_rule    = 1'b0;
        hold_off_req    = 1'b0;
        burst_left      = 0;
        items_sent      = 0;
        repeat (11) @(negedge aclk);
        aresetn = 1'b1;

        // directed: blacklist mode after reset
        write_filter_mode(1'b0);
        issue(CMD_CHECK, 32'h12345678, 32'h0, 6'd0, 1'b0);
        issue(CMD_ADD_SINGLE, 32'h00000000, 32'hffffffff, 6'd63, 1'b0);
        issue(CMD_ADD_SINGLE, ADDR_ALL_ONES, 32'h0, 6'd0, 1'b1);
        issue(CMD_ADD_SINGLE, ADDR_ALL_ONES, 32'h0, 6'd0, 1'b0);
        issue(CMD_ADD_RANGE, 32'd5, 32'd4, 6'd0, 1'b1);
        issue(CMD_ADD_RANGE, 32'd10, 32'd20, 6'd0, 1'b1);
        issue(CMD_ADD_RANGE, 32'd10, 32'd30, 6'd0, 1'b0);
        // reversed range with a begin already present reports reversed
        issue(CMD_ADD_RANGE, 32'd10, 32'd9, 6'd0, 1'b0);
        issue(CMD_ADD_CIDR, 32'hc0a80123, 32'h0, 6'd24, 1'b0);
        issue(CMD_ADD_CIDR, 32'h0a0b0c0d, 32'h0, 6'd40, 1'b1);
        issue(CMD_ADD_CIDR, 32'h01020304, 32'h0, 6'd0, 1'b1);
        issue(CMD_ADD_CIDR, ADDR_ALL_ONES, 32'h0, 6'd63, 1'b0);
        issue(CMD_CHECK, 32'h00000000, 32'h0, 6'd0, 1'b0);
        issue(CMD_CHECK, 32'd15, 32'h0, 6'd0, 1'b0);
        issue(CMD_CHECK, 32'hc0a801ff, 32'h0, 6'd0, 1'b0);
        issue(CMD_CHECK, ADDR_ALL_ONES, 32'h0, 6'd0, 1'b1);
        issue(CMD_CHECK, 32'h0a0b0c0d, 32'h0, 6'd0, 1'b0);
        issue(CMD_RSVD_FIRST, 32'hdeadbeef, 32'h12345678, 6'd17, 1'b1);
        issue(CMD_RSVD_LAST, ADDR_ALL_ONES, ADDR_ALL_ONES, 6'd63, 1'b1);
        issue(CMD_CLEAR, 32'h0, 32'h0, 6'd0, 1'b0);
        issue(CMD_CHECK, ADDR_ALL_ONES, 32'h0, 6'd0, 1'b0);
        settle();
        write_filter_mode(1'b1);
        issue(CMD_CHECK, 32'h12345678, 32'h0, 6'd0, 1'b0);
        settle();

        // random phases: fill the tables, then mixed traffic
        for (int p = 0; p < PHASES; p++) begin
            write_filter_mode((p < 2) ? p[0] : 1'($urandom_range(0, 1)));
            if ($urandom_range(0, 1)) issue(CMD_CLEAR, $urandom, $urandom, 6'($urandom), 1'b0);
            phase_start = items_sent;
            fill = $urandom_range(6, 36);
            for (int k = 0; k < fill; k++) begin
                pace_sender();
                random_add();
            end
            if (p == 3) hold_off_req = 1'b1;
            while (items_sent - phase_start < PHASE_ITEMS) begin
                pace_sender();
                random_command();
            end
            settle();
        end

        sb.flush_leftovers();
        $display("covered %0d results: %0d checks (%0d accepted, %0d blacklist, %0d whitelist)",
                 sb.n_results, sb.n_checks, sb.n_accepts, sb.mode_seen[0], sb.mode_seen[1]);
        $display("rule adds: %0d stored, %0d duplicate, %0d reversed, %0d full; %0d clears",
                 sb.n_added, sb.n_dup, sb.n_rev, sb.n_full, sb.n_clears);
        if (sb.errors == 0) begin
            $display("tb_ip_address_acl_filter_core OK");
        end else begin
            $display("tb_ip_address_acl_filter_core NOT OK");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
sv/ipacl_pkg.sv
sv/ipacl_single_cell.sv
sv/ipacl_range_cell.sv
sv/ip_address_acl_filter_core.sv
bench/tb_ip_address_acl_filter_core.sv
